// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the CRSF frame receiver.
// No dependencies; SYNTH selects the empty forms for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/crsf_pkg.sv -----
// Package of the CRSF frame receiver: field widths, protocol constants
// and the result record. No dependencies.
package crsf_pkg;

    localparam int DATA_W                = 8;
    localparam int COUNT_W               = 6;
    localparam int KIND_W                = 2;
    localparam int INDEX_W               = 4;
    localparam int VALUE_W               = 11;
    localparam int FRAME_STORE_DEPTH_DEF = 32;
    localparam int RC_PAYLOAD_BYTES      = 22;

    localparam logic [DATA_W-1:0]  DEVICE_ADDR_RESET = 8'hC8;
    localparam logic [DATA_W-1:0]  CRC_POLY          = 8'hD5;
    localparam logic [DATA_W-1:0]  TYPE_STATS        = 8'h14;
    localparam logic [DATA_W-1:0]  TYPE_RC           = 8'h16;
    localparam logic [COUNT_W-1:0] LEN_RC            = 6'd24;
    localparam logic [COUNT_W-1:0] LEN_STATS         = 6'd12;
    localparam logic [INDEX_W-1:0] STATS_LAST_INDEX  = 4'd9;
    localparam logic [INDEX_W-1:0] RC_LAST_INDEX     = 4'd15;

    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STATS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RC    = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  frame_kind;
        logic [INDEX_W-1:0] item_index;
        logic [VALUE_W-1:0] item_value;
        logic               last_item;
        logic               link_up;
    } result_t;

endpackage

// ----- rtl/crsf_ifs.sv -----
// Channel interfaces of the CRSF frame receiver: received bytes in, results out.
// Depends on crsf_pkg for the field widths.
interface crsf_rx_if
    import crsf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crsf_res_if
    import crsf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  frame_kind;
    logic [INDEX_W-1:0] item_index;
    logic [VALUE_W-1:0] item_value;
    logic               last_item;
    logic               link_up;

    modport source (output valid, output frame_kind, output item_index, output item_value,
                    output last_item, output link_up, input ready);
    modport sink   (input valid, input frame_kind, input item_index, input item_value,
                    input last_item, input link_up, output ready);
endinterface

// ----- rtl/crsf_frame_receiver.sv -----
// Top level of the CRSF frame receiver: framing, bit-serial CRC-8 and
// bit-serial channel unpacking. Depends on crsf_pkg, crsf_ifs, crsf_ram, assert_macros.svh.
//
//   channel   | role   | payload                                        | transaction
//   ----------+--------+------------------------------------------------+--------------------
//   rx        | sink   | rx_byte                                        | valid && ready
//   res       | source | frame_kind item_index item_value last_item     | valid && ready
//             |        | link_up                                        |
//   cfg_wr_*  | write  | device_address                                 | cfg_wr_en
//
// Address and length bytes are checked but not stored. Each type and payload byte is
// stored and then passed through the one-bit-per-cycle CRC-8 register. After the final
// CRC byte, an RC frame is unpacked from its 22 stored bytes, each a RAM read plus 8 shift
// steps, into 16 output loads; a statistics frame gives one item per stored payload byte
// and a bad frame a single error item. No new byte is taken until that work is done.
// Reset is asynchronous and clears all control state; the frame store is not cleared.
// A stalled result waits in the output register while the unpacker prepares the next.
`include "assert_macros.svh"

module crsf_frame_receiver
    import crsf_pkg::*;
#(
    parameter int FRAME_STORE_DEPTH = FRAME_STORE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [DATA_W-1:0] cfg_wr_data,
    crsf_rx_if.sink           rx,
    crsf_res_if.source        res
);

    localparam int STORE_AW = $clog2(FRAME_STORE_DEPTH);

    // Parser stage codes.
    localparam logic [1:0] PS_ADDR = 2'd0;
    localparam logic [1:0] PS_LEN  = 2'd1;
    localparam logic [1:0] PS_BODY = 2'd2;

    // Sequencer codes.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CRC   = 3'd1;
    localparam logic [2:0] ST_FETCH = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_SHIFT = 3'd4;
    localparam logic [2:0] ST_PUT   = 3'd5;

    logic [DATA_W-1:0]   dev_addr_reg, dev_addr_next;
    logic [1:0]          parse_reg, parse_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                is_rc_reg, is_rc_next;
    logic [DATA_W-1:0]   crc_reg, crc_next;
    logic [2:0]          crc_cnt_reg, crc_cnt_next;
    logic [DATA_W-1:0]   type_reg, type_next;
    logic                link_reg, link_next;
    logic [2:0]          seq_reg, seq_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [INDEX_W-1:0]  idx_reg, idx_next;
    logic [STORE_AW-1:0] rd_addr_reg, rd_addr_next;
    logic [DATA_W-1:0]   byte_sh_reg, byte_sh_next;
    logic [3:0]          bits_left_reg, bits_left_next;
    logic [VALUE_W-1:0]  chan_sh_reg, chan_sh_next;
    logic [3:0]          chan_bits_reg, chan_bits_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    logic                rx_acc;
    logic                out_free;
    logic [COUNT_W-1:0]  count_plus;
    logic [COUNT_W-1:0]  frame_len;
    logic                frame_good;
    logic                put_last;
    logic [VALUE_W-1:0]  put_value;
    logic                ram_wr;
    logic                ram_rd;
    logic [DATA_W-1:0]   ram_rd_data;

    // The frame store holds type, payload and CRC bytes at their offset from the type byte.
    crsf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (FRAME_STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (count_reg[STORE_AW-1:0]),
        .wr_data (rx.rx_byte),
        .rd_en   (ram_rd),
        .rd_addr (rd_addr_reg),
        .rd_data (ram_rd_data)
    );

    assign rx.ready  = (seq_reg == ST_IDLE);
    assign rx_acc    = rx.valid && rx.ready;
    assign out_free  = !out_valid_reg || res.ready;
    assign ram_rd    = (seq_reg == ST_FETCH);

    assign count_plus = count_reg + COUNT_W'(1);
    assign frame_len  = is_rc_reg ? LEN_RC : LEN_STATS;

    // The final byte is the received CRC; it is compared with the running value, which
    // has already absorbed the type and payload bytes.
    assign frame_good = (rx.rx_byte == crc_reg) &&
                        (((type_reg == TYPE_STATS) && !is_rc_reg) ||
                         ((type_reg == TYPE_RC) && is_rc_reg));

    assign put_last = (kind_reg == KIND_ERROR) ||
                      ((kind_reg == KIND_STATS) && (idx_reg == STATS_LAST_INDEX)) ||
                      ((kind_reg == KIND_RC) && (idx_reg == RC_LAST_INDEX));

    always_comb
    begin
        unique case (kind_reg)
            KIND_STATS: put_value = VALUE_W'(byte_sh_reg);
            KIND_RC:    put_value = chan_sh_reg;
            default:    put_value = '0;
        endcase
    end

    always_comb
    begin
        dev_addr_next  = dev_addr_reg;
        parse_next     = parse_reg;
        count_next     = count_reg;
        is_rc_next     = is_rc_reg;
        crc_next       = crc_reg;
        crc_cnt_next   = crc_cnt_reg;
        type_next      = type_reg;
        link_next      = link_reg;
        seq_next       = seq_reg;
        kind_next      = kind_reg;
        idx_next       = idx_reg;
        rd_addr_next   = rd_addr_reg;
        byte_sh_next   = byte_sh_reg;
        bits_left_next = bits_left_reg;
        chan_sh_next   = chan_sh_reg;
        chan_bits_next = chan_bits_reg;
        out_next       = out_reg;
        out_valid_next = res.ready ? 1'b0 : out_valid_reg;
        ram_wr         = 1'b0;

        if (cfg_wr_en)
        begin
            dev_addr_next = cfg_wr_data;
        end

        unique case (seq_reg)
            ST_IDLE:
            begin
                if (rx_acc)
                begin
                    unique case (parse_reg)
                        PS_ADDR:
                        begin
                            count_next = '0;
                            if (rx.rx_byte == dev_addr_reg)
                            begin
                                parse_next = PS_LEN;
                            end
                        end
                        PS_LEN:
                        begin
                            count_next = '0;
                            crc_next   = '0;
                            if ((rx.rx_byte == DATA_W'(LEN_RC)) ||
                                (rx.rx_byte == DATA_W'(LEN_STATS)))
                            begin
                                is_rc_next = (rx.rx_byte == DATA_W'(LEN_RC));
                                parse_next = PS_BODY;
                            end
                            else
                            begin
                                // A bad length byte is dropped, not retried as an address.
                                parse_next = PS_ADDR;
                            end
                        end
                        PS_BODY:
                        begin
                            ram_wr     = 1'b1;
                            count_next = count_plus;
                            if (count_reg == '0)
                            begin
                                type_next = rx.rx_byte;
                            end
                            if (count_plus < frame_len)
                            begin
                                crc_next     = crc_reg ^ rx.rx_byte;
                                crc_cnt_next = 3'(DATA_W - 1);
                                seq_next     = ST_CRC;
                            end
                            else
                            begin
                                parse_next     = PS_ADDR;
                                count_next     = '0;
                                crc_next       = '0;
                                idx_next       = '0;
                                chan_bits_next = '0;
                                rd_addr_next   = STORE_AW'(1);
                                if (frame_good)
                                begin
                                    link_next = 1'b1;
                                    kind_next = is_rc_reg ? KIND_RC : KIND_STATS;
                                    seq_next  = ST_FETCH;
                                end
                                else
                                begin
                                    kind_next = KIND_ERROR;
                                    seq_next  = ST_PUT;
                                end
                            end
                        end
                        default:
                        begin
                            parse_next = PS_ADDR;
                            count_next = '0;
                        end
                    endcase
                end
            end
            ST_CRC:
            begin
                // One bit of the CRC-8 division per cycle, MSB first.
                if (crc_reg[DATA_W-1])
                begin
                    crc_next = {crc_reg[DATA_W-2:0], 1'b0} ^ CRC_POLY;
                end
                else
                begin
                    crc_next = {crc_reg[DATA_W-2:0], 1'b0};
                end
                crc_cnt_next = crc_cnt_reg - 3'd1;
                if (crc_cnt_reg == '0)
                begin
                    seq_next = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                seq_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                byte_sh_next   = ram_rd_data;
                bits_left_next = 4'(DATA_W);
                seq_next       = (kind_reg == KIND_STATS) ? ST_PUT : ST_SHIFT;
            end
            ST_SHIFT:
            begin
                // Channels are packed LSB first; each bit enters at the top of the
                // channel register, so after eleven steps the first bit sits at bit 0.
                chan_sh_next   = {byte_sh_reg[0], chan_sh_reg[VALUE_W-1:1]};
                byte_sh_next   = {1'b0, byte_sh_reg[DATA_W-1:1]};
                bits_left_next = bits_left_reg - 4'd1;
                if (chan_bits_reg == 4'(VALUE_W - 1))
                begin
                    seq_next = ST_PUT;
                end
                else
                begin
                    chan_bits_next = chan_bits_reg + 4'd1;
                    if (bits_left_reg == 4'd1)
                    begin
                        rd_addr_next = rd_addr_reg + STORE_AW'(1);
                        seq_next     = ST_FETCH;
                    end
                end
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.frame_kind = kind_reg;
                    out_next.item_index = idx_reg;
                    out_next.item_value = put_value;
                    out_next.last_item  = put_last;
                    out_next.link_up    = link_reg;
                    idx_next            = idx_reg + INDEX_W'(1);
                    chan_bits_next      = '0;
                    if (put_last)
                    begin
                        seq_next = ST_IDLE;
                    end
                    else if ((kind_reg == KIND_RC) && (bits_left_reg != '0))
                    begin
                        seq_next = ST_SHIFT;
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg + STORE_AW'(1);
                        seq_next     = ST_FETCH;
                    end
                end
            end
            default:
            begin
                seq_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg  <= DEVICE_ADDR_RESET;
            parse_reg     <= PS_ADDR;
            count_reg     <= '0;
            is_rc_reg     <= 1'b0;
            crc_reg       <= '0;
            crc_cnt_reg   <= '0;
            link_reg      <= 1'b0;
            seq_reg       <= ST_IDLE;
            kind_reg      <= KIND_ERROR;
            idx_reg       <= '0;
            rd_addr_reg   <= '0;
            bits_left_reg <= '0;
            chan_bits_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dev_addr_reg  <= dev_addr_next;
            parse_reg     <= parse_next;
            count_reg     <= count_next;
            is_rc_reg     <= is_rc_next;
            crc_reg       <= crc_next;
            crc_cnt_reg   <= crc_cnt_next;
            link_reg      <= link_next;
            seq_reg       <= seq_next;
            kind_reg      <= kind_next;
            idx_reg       <= idx_next;
            rd_addr_reg   <= rd_addr_next;
            bits_left_reg <= bits_left_next;
            chan_bits_reg <= chan_bits_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        type_reg    <= type_next;
        byte_sh_reg <= byte_sh_next;
        chan_sh_reg <= chan_sh_next;
        out_reg     <= out_next;
    end

    assign res.valid      = out_valid_reg;
    assign res.frame_kind = out_reg.frame_kind;
    assign res.item_index = out_reg.item_index;
    assign res.item_value = out_reg.item_value;
    assign res.last_item  = out_reg.last_item;
    assign res.link_up    = out_reg.link_up;

    // A decoded frame has always raised the link flag before its first result.
    `ASSERT_IMPLIES(a_good_frame_link, clk, rst_n, res.valid && (res.frame_kind != KIND_ERROR), res.link_up, "decoded frame result without link_up")
    // An error is a single item with index and value zero.
    `ASSERT_IMPLIES(a_error_shape, clk, rst_n, res.valid && (res.frame_kind == KIND_ERROR), (res.item_index == '0) && (res.item_value == '0) && res.last_item, "malformed error item")
    // The unpacker only reads payload bytes of the store.
    `ASSERT_IMPLIES(a_fetch_range, clk, rst_n, seq_reg == ST_FETCH, (rd_addr_reg >= STORE_AW'(1)) && (rd_addr_reg <= STORE_AW'(RC_PAYLOAD_BYTES)), "store read outside the payload")
    // A result prepared while the output is free appears in the next cycle.
    `ASSERT_NEXT(a_put_lands, clk, rst_n, (seq_reg == ST_PUT) && out_free, res.valid, "prepared result was lost")

endmodule

// ----- rtl/crsf_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module crsf_ram
#(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
